[rtl/sarma_pkg.sv]
// ----------------------------------------------------------------------------
// sarma_pkg
// Shared word types, register map and fixed constants of the seasonal
// ARMA prediction-error filter.
// ----------------------------------------------------------------------------
package sarma_pkg;

  localparam int unsigned COEF_W      = 16;
  localparam int unsigned TERMS       = 4;   // coefficients packed per register
  localparam int unsigned ROUND_SHIFT = 14;
  localparam int unsigned ACC_W       = 64;
  localparam int unsigned ADDR_W      = 6;
  localparam int unsigned DATA_W      = 64;
  localparam logic [2:0]  SEEN_CAP    = 3'd5;

  localparam logic [2:0] REG_AR_ORDER  = 3'd0;
  localparam logic [2:0] REG_MA_ORDER  = 3'd1;
  localparam logic [2:0] REG_SAR_COUNT = 3'd2;
  localparam logic [2:0] REG_SMA_COUNT = 3'd3;
  localparam logic [2:0] REG_AR_COEF   = 3'd4;
  localparam logic [2:0] REG_MA_COEF   = 3'd5;
  localparam logic [2:0] REG_SAR_COEF  = 3'd6;
  localparam logic [2:0] REG_SMA_COEF  = 3'd7;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               sample_valid;
    logic [7:0]         seas_ar_lag_a;
    logic [7:0]         seas_ar_lag_b;
    logic [7:0]         seas_ar_lag_c;
    logic [7:0]         seas_ar_lag_d;
    logic [7:0]         seas_ma_lag_a;
    logic [7:0]         seas_ma_lag_b;
    logic [7:0]         seas_ma_lag_c;
    logic [7:0]         seas_ma_lag_d;
  } sarma_in_t;

  typedef struct packed {
    logic signed [31:0] seasonal_part;
    logic signed [31:0] adjusted;
    logic signed [31:0] predicted;
    logic signed [31:0] pred_error;
    logic               warming_up;
  } sarma_out_t;

  typedef struct packed {
    logic [2:0]  ar_order;
    logic [2:0]  ma_order;
    logic [2:0]  sar_count;
    logic [2:0]  sma_count;
    logic [63:0] ar_coef;
    logic [63:0] ma_coef;
    logic [63:0] sar_coef;
    logic [63:0] sma_coef;
  } sarma_cfg_t;

endpackage

[rtl/sarma_cfg.sv]
// ----------------------------------------------------------------------------
// sarma_cfg
// APB register bank: model orders, seasonal counts and packed coefficients.
// ----------------------------------------------------------------------------
module sarma_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sarma_pkg::ADDR_W-1:0] paddr,
  input  logic [sarma_pkg::DATA_W-1:0] pwdata,
  output logic [sarma_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output sarma_pkg::sarma_cfg_t     cfg_o
);
  import sarma_pkg::*;

  sarma_cfg_t cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        REG_AR_ORDER:  cfg_d.ar_order  = pwdata[2:0];
        REG_MA_ORDER:  cfg_d.ma_order  = pwdata[2:0];
        REG_SAR_COUNT: cfg_d.sar_count = pwdata[2:0];
        REG_SMA_COUNT: cfg_d.sma_count = pwdata[2:0];
        REG_AR_COEF:   cfg_d.ar_coef   = pwdata;
        REG_MA_COEF:   cfg_d.ma_coef   = pwdata;
        REG_SAR_COEF:  cfg_d.sar_coef  = pwdata;
        REG_SMA_COEF:  cfg_d.sma_coef  = pwdata;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_AR_ORDER:  prdata = DATA_W'(cfg_q.ar_order);
      REG_MA_ORDER:  prdata = DATA_W'(cfg_q.ma_order);
      REG_SAR_COUNT: prdata = DATA_W'(cfg_q.sar_count);
      REG_SMA_COUNT: prdata = DATA_W'(cfg_q.sma_count);
      REG_AR_COEF:   prdata = cfg_q.ar_coef;
      REG_MA_COEF:   prdata = cfg_q.ma_coef;
      REG_SAR_COEF:  prdata = cfg_q.sar_coef;
      REG_SMA_COEF:  prdata = cfg_q.sma_coef;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= sarma_cfg_t'{ar_order: 3'd1, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/sarma_hist_mem.sv]
// ----------------------------------------------------------------------------
// sarma_hist_mem
// History store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sarma_hist_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 161
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

endmodule

[rtl/sarma_mac.sv]
// ----------------------------------------------------------------------------
// sarma_mac
// Shared multiply-accumulate with a saturating 64-bit sum, plus rounding
// of the sum back to the sample format.
// ----------------------------------------------------------------------------
module sarma_mac #(
  parameter int unsigned W = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  step_i,
  input  logic                                  clear_i,
  input  logic                                  en_i,
  input  logic signed [W-1:0]                   operand_i,
  input  logic signed [sarma_pkg::COEF_W-1:0]   coef_i,
  output logic signed [W-1:0]                   round_o
);
  import sarma_pkg::*;

  localparam int unsigned SH_W = ACC_W - ROUND_SHIFT;
  localparam logic signed [SH_W-1:0] MAXW = (SH_W'(1) <<< (W - 1)) - SH_W'(1);
  localparam logic signed [SH_W-1:0] MINW = -MAXW - SH_W'(1);

  logic signed [W+COEF_W-1:0] prod;
  logic signed [ACC_W-1:0]    term, base, acc_q, acc_d, rnd;
  logic signed [ACC_W:0]      sum, rsum;
  logic signed [SH_W-1:0]     sh;

  assign prod = operand_i * coef_i;
  assign term = en_i ? ACC_W'(prod) : '0;
  assign base = clear_i ? '0 : acc_q;
  assign sum  = {base[ACC_W-1], base} + {term[ACC_W-1], term};

  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_d = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_d = sum[ACC_W-1:0];
    end
  end

  // round half up, then floor shift
  assign rsum = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(1 << (ROUND_SHIFT - 1));

  always_comb begin
    if (rsum[ACC_W] != rsum[ACC_W-1]) begin
      rnd = rsum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      rnd = rsum[ACC_W-1:0];
    end
  end

  assign sh = rnd[ACC_W-1:ROUND_SHIFT];

  always_comb begin
    if (sh > MAXW) begin
      round_o = {1'b0, {(W-1){1'b1}}};
    end else if (sh < MINW) begin
      round_o = {1'b1, {(W-1){1'b0}}};
    end else begin
      round_o = sh[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (step_i) begin
      acc_q <= acc_d;
    end
  end

endmodule

[rtl/seasonal_arma_filter.sv]
// ----------------------------------------------------------------------------
// seasonal_arma_filter
// Seasonal ARMA prediction-error filter: per sample, history lookups and
// up to sixteen multiply-accumulates through one shared MAC.
//
//  channel   direction  handshake               word
//  in        input      in_valid_i / in_stall_o  sarma_in_t
//  out       output     out_valid_o / out_stall_i sarma_out_t
//  cfg       input      APB psel/penable/pready  64-bit registers
//
// A sample passes through accept, 13 reads of the single history port,
// 16 MAC steps, a rounding step and a write-back step. During warm-up a
// sample goes from accept straight to write-back.
// After reset a clearing pass writes every history entry with zero fields and
// the present flag set, with the input stalled; configuration writes are taken
// meanwhile. The result waits in an output register; the next sample is taken
// while it waits, and write-back holds until that register is free.
// ----------------------------------------------------------------------------
module seasonal_arma_filter #(
  parameter int unsigned AR_TAPS       = 4,
  parameter int unsigned MA_TAPS       = 4,
  parameter int unsigned SEASONAL_TAPS = 4,
  parameter int unsigned HISTORY_DEPTH = 256,
  parameter int unsigned SAMPLE_WIDTH  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sarma_pkg::sarma_in_t          in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sarma_pkg::sarma_out_t         out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sarma_pkg::ADDR_W-1:0]  paddr,
  input  logic [sarma_pkg::DATA_W-1:0]  pwdata,
  output logic [sarma_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);
  import sarma_pkg::*;

  localparam int unsigned W   = SAMPLE_WIDTH;
  localparam int unsigned AW  = $clog2(HISTORY_DEPTH);
  localparam int unsigned EW  = 5 * W + 1;
  localparam logic [2:0] AR_CAP  = 3'(AR_TAPS < TERMS ? AR_TAPS : TERMS);
  localparam logic [2:0] MA_CAP  = 3'(MA_TAPS < TERMS ? MA_TAPS : TERMS);
  localparam logic [2:0] SEA_CAP = 3'(SEASONAL_TAPS < TERMS ? SEASONAL_TAPS : TERMS);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_MAC  = 3'd3;
  localparam logic [2:0] ST_FS   = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  localparam logic [3:0] RD_LAST  = 4'd12;
  localparam logic [3:0] MAC_LAST = 4'd15;
  localparam logic [3:0] MAC_MID  = 4'd8;

  function automatic logic signed [W-1:0] sat_w(input logic signed [W:0] s);
    logic signed [W-1:0] r;
    if (s[W] != s[W-1]) begin
      r = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      r = s[W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    return sat_w({a[W-1], a} + {b[W-1], b});
  endfunction

  function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    return sat_w({a[W-1], a} - {b[W-1], b});
  endfunction

  sarma_cfg_t cfg;

  sarma_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // effective orders
  logic [2:0] nar, nma, nsar, nsma, pq;
  logic       seasonal;

  assign nar  = (cfg.ar_order  > AR_CAP)  ? AR_CAP  : cfg.ar_order;
  assign nma  = (cfg.ma_order  > MA_CAP)  ? MA_CAP  : cfg.ma_order;
  assign nsar = (cfg.sar_count > SEA_CAP) ? SEA_CAP : cfg.sar_count;
  assign nsma = (cfg.sma_count > SEA_CAP) ? SEA_CAP : cfg.sma_count;
  assign pq   = (nar > nma) ? nar : nma;
  assign seasonal = (nsar != 3'd0) || (nsma != 3'd0);

  // lag modulo depth, constant per lag value
  logic [AW-1:0] lag_mod [256];
  for (genvar g = 0; g < 256; g++) begin : g_lag
    assign lag_mod[g] = AW'(g % HISTORY_DEPTH);
  end

  logic signed [W-1:0] x_in;
  if (W > 32) begin : g_wide
    assign x_in = $signed({{(W-32){1'b0}}, in_data_i.sample});
  end else begin : g_narrow
    assign x_in = $signed(in_data_i.sample[W-1:0]);
  end

  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       wp_q, clr_q;
  logic [2:0]          seen_q;
  logic [3:0]          rc_q, kc_q;
  sarma_in_t           item_q;
  logic signed [W-1:0] x_q, yp_q, s_q;
  logic                warm_q;
  logic                out_valid_q;
  sarma_out_t          out_q;

  logic signed [W-1:0] t_adj [TERMS];
  logic signed [W-1:0] t_err [TERMS];
  logic signed [W-1:0] t_smp [TERMS];
  logic signed [W-1:0] t_prd [TERMS];
  logic [TERMS-1:0]    t_pres;
  logic signed [W-1:0] s_smp [TERMS];
  logic signed [W-1:0] s_ps  [TERMS];
  logic [TERMS-1:0]    s_pres;
  logic signed [W-1:0] m_adj [TERMS];

  logic [7:0] ar_lag [TERMS];
  logic [7:0] ma_lag [TERMS];
  assign ar_lag[0] = item_q.seas_ar_lag_a;
  assign ar_lag[1] = item_q.seas_ar_lag_b;
  assign ar_lag[2] = item_q.seas_ar_lag_c;
  assign ar_lag[3] = item_q.seas_ar_lag_d;
  assign ma_lag[0] = item_q.seas_ma_lag_a;
  assign ma_lag[1] = item_q.seas_ma_lag_b;
  assign ma_lag[2] = item_q.seas_ma_lag_c;
  assign ma_lag[3] = item_q.seas_ma_lag_d;

  // read address for the current read slot
  logic [7:0]    lag_sel;
  logic [AW:0]   back_sum;
  logic [AW-1:0] raddr;

  always_comb begin
    case (rc_q[3:2])
      2'd0:    lag_sel = 8'(rc_q[1:0]) + 8'd1;
      2'd1:    lag_sel = ar_lag[rc_q[1:0]];
      default: lag_sel = ma_lag[rc_q[1:0]];
    endcase
  end

  assign back_sum = {1'b0, wp_q} + (AW+1)'(HISTORY_DEPTH) - {1'b0, lag_mod[lag_sel]};
  assign raddr    = (back_sum >= (AW+1)'(HISTORY_DEPTH))
                    ? AW'(back_sum - (AW+1)'(HISTORY_DEPTH)) : back_sum[AW-1:0];

  // history entry fields
  logic [EW-1:0]       rdata, wdata;
  logic                we;
  logic [AW-1:0]       waddr;
  logic signed [W-1:0] r_seas, r_err, r_prd, r_adj, r_smp;
  logic                r_pres;

  assign r_seas = rdata[W-1:0];
  assign r_err  = rdata[2*W-1:W];
  assign r_prd  = rdata[3*W-1:2*W];
  assign r_adj  = rdata[4*W-1:3*W];
  assign r_smp  = rdata[5*W-1:4*W];
  assign r_pres = rdata[5*W];

  // MAC term selection
  logic                gap_a, gap_s;
  logic                m_en;
  logic signed [W-1:0] m_opd;
  logic [COEF_W-1:0]   m_coef;
  logic [1:0]          kj;
  logic signed [W-1:0] m_round;

  always_comb begin
    gap_a = 1'b0;
    gap_s = 1'b0;
    for (int j = 0; j < TERMS; j++) begin
      if (3'(j) < nar && !t_pres[j]) gap_a = 1'b1;
      if (3'(j) < nsar && !s_pres[j]) gap_s = 1'b1;
    end
  end

  assign kj = kc_q[1:0];

  always_comb begin
    case (kc_q[3:2])
      2'd0: begin
        m_en   = 3'(kj) < nar;
        m_opd  = seasonal ? t_adj[kj] : (gap_a ? t_prd[kj] : t_smp[kj]);
        m_coef = cfg.ar_coef[{kj, 4'b0} +: COEF_W];
      end
      2'd1: begin
        m_en   = 3'(kj) < nma;
        m_opd  = t_err[kj];
        m_coef = cfg.ma_coef[{kj, 4'b0} +: COEF_W];
      end
      2'd2: begin
        m_en   = 3'(kj) < nsar;
        m_opd  = gap_s ? s_ps[kj] : s_smp[kj];
        m_coef = cfg.sar_coef[{kj, 4'b0} +: COEF_W];
      end
      default: begin
        m_en   = 3'(kj) < nsma;
        m_opd  = m_adj[kj];
        m_coef = cfg.sma_coef[{kj, 4'b0} +: COEF_W];
      end
    endcase
  end

  sarma_mac #(.W(W)) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (state_q == ST_MAC),
    .clear_i   ((kc_q == 4'd0) || (kc_q == MAC_MID)),
    .en_i      (m_en),
    .operand_i (m_opd),
    .coef_i    ($signed(m_coef)),
    .round_o   (m_round)
  );

  // final values
  logic signed [W-1:0] ya_c, e_c;
  logic                fire, accept;

  always_comb begin
    if (warm_q) begin
      ya_c = '0;
      e_c  = '0;
    end else if (seasonal) begin
      ya_c = item_q.sample_valid ? sat_sub(x_q, s_q) : yp_q;
      e_c  = sat_sub(ya_c, yp_q);
    end else begin
      ya_c = '0;
      e_c  = item_q.sample_valid ? sat_sub(x_q, yp_q) : '0;
    end
  end

  assign fire   = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  assign accept = (state_q == ST_IDLE) && in_valid_i;

  always_comb begin
    we    = 1'b0;
    waddr = wp_q;
    wdata = {1'b1, {(5*W){1'b0}}};
    if (state_q == ST_CLR) begin
      we    = 1'b1;
      waddr = clr_q;
    end else if (fire) begin
      we    = 1'b1;
      wdata = {item_q.sample_valid, (item_q.sample_valid ? x_q : {W{1'b0}}),
               ya_c, yp_q, e_c, s_q};
    end
  end

  sarma_hist_mem #(.DEPTH(HISTORY_DEPTH), .WIDTH(EW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLR:  if (clr_q == AW'(HISTORY_DEPTH - 1)) state_d = ST_IDLE;
      ST_IDLE: if (in_valid_i) state_d = (seen_q < pq) ? ST_FIN : ST_RD;
      ST_RD:   if (rc_q == RD_LAST) state_d = ST_MAC;
      ST_MAC:  if (kc_q == MAC_LAST) state_d = ST_FS;
      ST_FS:   state_d = ST_FIN;
      ST_FIN:  if (fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      wp_q        <= '0;
      seen_q      <= '0;
      rc_q        <= '0;
      kc_q        <= '0;
      warm_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLR) clr_q <= clr_q + AW'(1);
      if (accept) begin
        warm_q <= seen_q < pq;
        rc_q   <= '0;
        kc_q   <= '0;
      end
      if (state_q == ST_RD) rc_q <= rc_q + 4'd1;
      if (state_q == ST_MAC) kc_q <= kc_q + 4'd1;
      if (fire) begin
        out_valid_q <= 1'b1;
        wp_q        <= (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
        if (seen_q < SEEN_CAP) seen_q <= seen_q + 3'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  logic [3:0] slot;
  assign slot = rc_q - 4'd1;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
      x_q    <= x_in;
      yp_q   <= '0;
      s_q    <= '0;
    end
    if (state_q == ST_RD && rc_q != 4'd0) begin
      case (slot[3:2])
        2'd0: begin
          t_adj[slot[1:0]]  <= r_adj;
          t_err[slot[1:0]]  <= r_err;
          t_smp[slot[1:0]]  <= r_smp;
          t_prd[slot[1:0]]  <= r_prd;
          t_pres[slot[1:0]] <= r_pres;
        end
        2'd1: begin
          s_smp[slot[1:0]]  <= r_smp;
          s_ps[slot[1:0]]   <= sat_add(r_prd, r_seas);
          s_pres[slot[1:0]] <= r_pres;
        end
        2'd2: m_adj[slot[1:0]] <= r_adj;
        default: ;
      endcase
    end
    // prediction sum is complete once the MA terms are in
    if (state_q == ST_MAC && kc_q == MAC_MID) yp_q <= m_round;
    if (state_q == ST_FS) s_q <= m_round;
    if (fire) begin
      out_q.seasonal_part <= 32'(s_q);
      out_q.adjusted      <= 32'(ya_c);
      out_q.predicted     <= 32'(yp_q);
      out_q.pred_error    <= 32'(e_c);
      out_q.warming_up    <= warm_q;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
